// ----- rtl/icre_pkg.sv -----
// Shared types, codes and helpers for the int8 3x3 convolution engine.
package icre_pkg;

    localparam int LANES  = 8;
    localparam int KERNEL = 3;
    localparam int TAPS   = KERNEL * KERNEL;

    localparam int DEF_MAX_HEIGHT       = 64;
    localparam int DEF_MAX_WIDTH        = 64;
    localparam int DEF_MAX_IN_CHANNELS  = 32;
    localparam int DEF_MAX_OUT_CHANNELS = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT   = 2'd0,
        CFG_WIDTH    = 2'd1,
        CFG_IN_CH    = 2'd2,
        CFG_OUT_CH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_ACT   = 2'd0,
        MODE_WGT   = 2'd1,
        MODE_BIAS  = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]        mode;
        logic [5:0]        row;
        logic [5:0]        col;
        logic [4:0]        in_channel;
        logic [5:0]        out_channel;
        logic [3:0]        tap;
        logic signed [7:0] value;
    } t_in_word;

    typedef struct packed {
        logic [5:0] out_row;
        logic [5:0] out_col;
        logic [5:0] channel_base;
        logic       in_range;
        logic [6:0] result_0;
        logic [6:0] result_1;
        logic [6:0] result_2;
        logic [6:0] result_3;
        logic [6:0] result_4;
        logic [6:0] result_5;
        logic [6:0] result_6;
        logic [6:0] result_7;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic init;
        logic step;
        logic emit;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic nin_zero;
        logic pipe_empty;
    } t_sts;

    // channel group of a 6-bit channel number (floor of v / LANES), by table compare
    function automatic logic [5:0] grp_of(input logic [5:0] v);
        logic [5:0] g;
        g = '0;
        for (int k = 0; k < 64; k++) begin
            if (k * LANES <= int'(v)) begin
                g = 6'(k);
            end
        end
        return g;
    endfunction

endpackage

// ----- rtl/icre_ctrl.sv -----
// Sequencer for one query: bias load, multiply-accumulate sweep, drain, emit.
module icre_ctrl
    import icre_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_mode    i_mode,
    input  t_sts     i_sts,
    output t_ctl     o_ctl,
    output logic     busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && i_mode == MODE_QUERY) n_state = ST_INIT;
            end
            ST_INIT: begin
                n_state = i_sts.nin_zero ? ST_DRAIN : ST_RUN;
            end
            ST_RUN: begin
                if (i_sts.last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_sts.pipe_empty) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy         = 1'b0;
                o_ctl.accept = start;
            end
            ST_INIT:  o_ctl.init = 1'b1;
            ST_RUN:   o_ctl.step = 1'b1;
            ST_DRAIN: o_ctl      = '0;
            ST_EMIT:  o_ctl.emit = 1'b1;
            default:  o_ctl      = '0;
        endcase
    end

endmodule

// ----- rtl/icre_datapath.sv -----
// Stores, configuration, 3x3 window walk, eight MAC lanes and output clamp.
module icre_datapath
    import icre_pkg::*;
#(
    parameter int MAX_HEIGHT       = DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
    parameter int MAX_IN_CHANNELS  = DEF_MAX_IN_CHANNELS,
    parameter int MAX_OUT_CHANNELS = DEF_MAX_OUT_CHANNELS
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_word              i_item,
    input  t_ctl                  i_ctl,
    output t_sts                  o_sts,
    output logic                  o_valid,
    output t_out_word             o_result
);

    localparam int ADEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_IN_CHANNELS;
    localparam int AAW    = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
    localparam int NGRP   = (MAX_OUT_CHANNELS + LANES - 1) / LANES;
    localparam int GW     = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int WDEPTH = NGRP * MAX_IN_CHANNELS * TAPS;
    localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int CW     = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
    localparam int LW     = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int ACC_W  = 18 + $clog2(MAX_IN_CHANNELS * TAPS + 1);

    // configuration
    logic [6:0] r_height, r_width, r_out_ch;
    logic [5:0] r_in_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= 7'd64;
            r_width  <= 7'd64;
            r_in_ch  <= 6'd32;
            r_out_ch <= 7'd64;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_IN_CH:  r_in_ch  <= i_cfg_data[5:0];
                CFG_OUT_CH: r_out_ch <= i_cfg_data;
                default:    r_height <= r_height;
            endcase
        end
    end

    logic [6:0] w_h, w_w, w_nout;
    logic [8:0] w_nin;

    always_comb begin
        w_h    = (int'(r_height) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : r_height;
        w_w    = (int'(r_width) > MAX_WIDTH) ? 7'(MAX_WIDTH) : r_width;
        w_nin  = (int'(r_in_ch) > MAX_IN_CHANNELS) ? 9'(MAX_IN_CHANNELS) : 9'(r_in_ch);
        w_nout = (int'(r_out_ch) > MAX_OUT_CHANNELS) ? 7'(MAX_OUT_CHANNELS) : r_out_ch;
    end

    // decode of the incoming word
    logic [5:0]     w_in_grp;
    logic [LW-1:0]  w_in_lane;
    logic [AAW-1:0] w_act_waddr;
    logic [WAW-1:0] w_wgt_waddr;
    logic           w_act_ok, w_wgt_ok, w_bias_ok;

    always_comb begin
        w_in_grp    = grp_of(i_item.out_channel);
        w_in_lane   = LW'(int'(i_item.out_channel) - int'(w_in_grp) * LANES);
        w_act_ok    = int'(i_item.row) < MAX_HEIGHT && int'(i_item.col) < MAX_WIDTH
                   && int'(i_item.in_channel) < MAX_IN_CHANNELS;
        w_wgt_ok    = int'(i_item.out_channel) < MAX_OUT_CHANNELS
                   && int'(i_item.in_channel) < MAX_IN_CHANNELS && int'(i_item.tap) < TAPS;
        w_bias_ok   = int'(i_item.out_channel) < MAX_OUT_CHANNELS;
        w_act_waddr = AAW'((int'(i_item.row) * MAX_WIDTH + int'(i_item.col))
                           * MAX_IN_CHANNELS + int'(i_item.in_channel));
        w_wgt_waddr = WAW'((int'(w_in_grp) * MAX_IN_CHANNELS + int'(i_item.in_channel))
                           * TAPS + int'(i_item.tap));
    end

    // stores
    logic signed [7:0] r_act_mem  [ADEPTH];
    logic signed [7:0] r_wgt_mem  [LANES][WDEPTH];
    logic signed [7:0] r_bias_mem [LANES][NGRP];

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && t_mode'(i_item.mode) == MODE_ACT && w_act_ok) begin
            r_act_mem[w_act_waddr] <= i_item.value;
        end
        if (i_ctl.accept && t_mode'(i_item.mode) == MODE_WGT && w_wgt_ok) begin
            r_wgt_mem[w_in_lane][w_wgt_waddr] <= i_item.value;
        end
        if (i_ctl.accept && t_mode'(i_item.mode) == MODE_BIAS && w_bias_ok) begin
            r_bias_mem[w_in_lane][GW'(w_in_grp)] <= i_item.value;
        end
    end

    // query fields, bias fetched on accept
    logic [5:0]        r_row, r_col, r_grp;
    logic              r_in_range;
    logic signed [7:0] r_bias [LANES];

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && t_mode'(i_item.mode) == MODE_QUERY) begin
            r_row      <= i_item.row;
            r_col      <= i_item.col;
            r_grp      <= w_in_grp;
            r_in_range <= ({1'b0, i_item.row} < w_h) && ({1'b0, i_item.col} < w_w);
            for (int k = 0; k < LANES; k++) begin
                r_bias[k] <= r_bias_mem[k][GW'(w_in_grp)];
            end
        end
    end

    // window walk counters
    logic [CW-1:0] r_c;
    logic [1:0]    r_kr, r_kc;
    logic [3:0]    r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_c  <= '0;
            r_kr <= '0;
            r_kc <= '0;
            r_t  <= '0;
        end else if (i_ctl.step) begin
            if (int'(r_t) == TAPS - 1) begin
                r_t  <= '0;
                r_kr <= '0;
                r_kc <= '0;
                r_c  <= r_c + 1'b1;
            end else begin
                r_t <= r_t + 4'd1;
                if (int'(r_kc) == KERNEL - 1) begin
                    r_kc <= '0;
                    r_kr <= r_kr + 2'd1;
                end else begin
                    r_kc <= r_kc + 2'd1;
                end
            end
        end
    end

    logic signed [7:0] w_nr, w_nc;
    logic              w_inframe;
    logic [AAW-1:0]    w_act_raddr;
    logic [WAW-1:0]    w_wgt_raddr;

    always_comb begin
        w_nr = $signed({2'b00, r_row}) + $signed({6'd0, r_kr}) - 8'sd1;
        w_nc = $signed({2'b00, r_col}) + $signed({6'd0, r_kc}) - 8'sd1;
        w_inframe = (w_nr >= 0) && (w_nc >= 0)
                 && (w_nr < $signed({1'b0, w_h})) && (w_nc < $signed({1'b0, w_w}));
        w_act_raddr = AAW'((int'(w_nr[6:0]) * MAX_WIDTH + int'(w_nc[6:0]))
                           * MAX_IN_CHANNELS + int'(r_c));
        w_wgt_raddr = WAW'((int'(r_grp) * MAX_IN_CHANNELS + int'(r_c)) * TAPS + int'(r_t));
    end

    // stage A: addresses, B: store read, C: products, then accumulate
    logic                r_a_vld, r_b_vld, r_c_vld;
    logic [AAW-1:0]      r_a_aaddr;
    logic [WAW-1:0]      r_a_waddr;
    logic signed [7:0]   r_b_act;
    logic signed [7:0]   r_b_wgt [LANES];
    logic signed [15:0]  r_prod  [LANES];
    logic signed [ACC_W-1:0] r_acc [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_ctl.step && w_inframe;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_aaddr <= w_act_raddr;
        r_a_waddr <= w_wgt_raddr;
        r_b_act   <= r_act_mem[r_a_aaddr];
        for (int k = 0; k < LANES; k++) begin
            r_b_wgt[k] <= r_wgt_mem[k][r_a_waddr];
            r_prod[k]  <= r_b_act * r_b_wgt[k];
            if (i_ctl.init) begin
                r_acc[k] <= ACC_W'(r_bias[k]);
            end else if (r_c_vld) begin
                r_acc[k] <= r_acc[k] + ACC_W'(r_prod[k]);
            end
        end
    end

    always_comb begin
        o_sts.last       = (9'(r_c) + 9'd1 == w_nin) && (int'(r_t) == TAPS - 1);
        o_sts.nin_zero   = (w_nin == 9'd0);
        o_sts.pipe_empty = !r_a_vld && !r_b_vld && !r_c_vld;
    end

    // clamp and output word
    logic [6:0]              w_res [LANES];
    logic signed [ACC_W-1:0] w_sh;
    logic [7:0]              w_ch;

    always_comb begin
        w_sh = '0;
        w_ch = '0;
        for (int k = 0; k < LANES; k++) begin
            w_sh = r_acc[k] >>> 8;
            w_ch = 8'(int'(r_grp) * LANES + k);
            if (!r_in_range || w_ch >= {1'b0, w_nout} || r_acc[k] < 0) begin
                w_res[k] = '0;
            end else if (w_sh > ACC_W'(127)) begin
                w_res[k] = 7'd127;
            end else begin
                w_res[k] = w_sh[6:0];
            end
        end
    end

    logic      r_valid;
    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out.out_row      <= r_row;
            r_out.out_col      <= r_col;
            r_out.channel_base <= 6'(int'(r_grp) * LANES);
            r_out.in_range     <= r_in_range;
            r_out.result_0     <= w_res[0];
            r_out.result_1     <= w_res[1];
            r_out.result_2     <= w_res[2];
            r_out.result_3     <= w_res[3];
            r_out.result_4     <= w_res[4];
            r_out.result_5     <= w_res[5];
            r_out.result_6     <= w_res[6];
            r_out.result_7     <= w_res[7];
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// ----- rtl/int8_conv3x3_relu_engine.sv -----
// Top level of the int8 3x3 convolution engine with output clamp.
// Load words (activation, weight, bias) are written while the engine is idle and
// can follow one another back to back. A query's length is set by the single
// activation read port: one window tap of one input channel is fetched per cycle
// and fed to eight MAC lanes at once. The drain ends sooner when the last taps of
// the window fall outside the frame; with zero input channels a query skips the
// multiply-accumulate sweep and goes straight to the drain.
// The result word is shown for one cycle only and the receiver cannot stall it;
// busy stays high until that cycle, so the next word can start right after.
module int8_conv3x3_relu_engine
    import icre_pkg::*;
#(
    parameter int MAX_HEIGHT       = DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
    parameter int MAX_IN_CHANNELS  = DEF_MAX_IN_CHANNELS,
    parameter int MAX_OUT_CHANNELS = DEF_MAX_OUT_CHANNELS
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  t_in_word              i_item,
    output logic                  o_valid,
    output t_out_word             o_result
);

    t_ctl w_ctl;
    t_sts w_sts;

    icre_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (t_mode'(i_item.mode)),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .busy    (busy)
    );

    icre_datapath #(
        .MAX_HEIGHT       (MAX_HEIGHT),
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

// ----- tb/int8_conv3x3_relu_engine_tb.sv -----
// Self-checking testbench for the int8 3x3 convolution engine: predicts every query word.
module int8_conv3x3_relu_engine_tb;
    import icre_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    t_in_word              i_item = '0;
    logic                  o_valid;
    t_out_word             o_result;

    int8_conv3x3_relu_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_result(o_result)
    );

    // shadow stores and written flags
    logic signed [7:0] act_mem  [0:131071];
    logic signed [7:0] wgt_mem  [0:18431];
    logic signed [7:0] bias_mem [0:63];
    bit                act_set  [0:131071];
    bit                wgt_set  [0:18431];
    bit                bias_set [0:63];

    int cfg_h = 64, cfg_w = 64, cfg_nin = 32, cfg_nout = 64;

    t_in_word  word_q [$];
    t_out_word pixel_q [$];
    int        gap_cnt = 0;
    bit        idle_on = 1'b1;
    int        err_cnt = 0;
    int        mism_cnt = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int cap(input int v, input int m);
        return (v > m) ? m : v;
    endfunction

    function automatic int act_idx(input int r, input int c, input int ch);
        return (r * 64 + c) * 32 + ch;
    endfunction

    function automatic int wgt_idx(input int oc, input int ic, input int t);
        return (oc * 32 + ic) * 9 + t;
    endfunction

    function automatic logic signed [7:0] rand_val();
        case ($urandom_range(0, 7))
            0: return 8'sd127;
            1: return -8'sd128;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_out_word predict_pixel(input t_in_word w);
        t_out_word p;
        int h, wd, nin, nout, base, ch, sum, r, q;
        logic [6:0] lane [8];
        h = cap(cfg_h, 64);
        wd = cap(cfg_w, 64);
        nin = cap(cfg_nin, 32);
        nout = cap(cfg_nout, 64);
        base = int'(w.out_channel) / LANES * LANES;
        p = '0;
        p.out_row = w.row;
        p.out_col = w.col;
        p.channel_base = 6'(base);
        p.in_range = (int'(w.row) < h && int'(w.col) < wd);
        for (int k = 0; k < LANES; k++) begin
            lane[k] = '0;
            ch = base + k;
            if (p.in_range && ch < nout) begin
                sum = bias_mem[ch];
                for (int c = 0; c < nin; c++) begin
                    for (int t = 0; t < TAPS; t++) begin
                        r = int'(w.row) + t / 3 - 1;
                        q = int'(w.col) + t % 3 - 1;
                        if (r >= 0 && q >= 0 && r < h && q < wd)
                            sum += act_mem[act_idx(r, q, c)] * wgt_mem[wgt_idx(ch, c, t)];
                    end
                end
                if (sum < 0) lane[k] = '0;
                else if ((sum >>> 8) > 127) lane[k] = 7'd127;
                else lane[k] = 7'(sum >>> 8);
            end
        end
        p.result_0 = lane[0]; p.result_1 = lane[1]; p.result_2 = lane[2];
        p.result_3 = lane[3]; p.result_4 = lane[4]; p.result_5 = lane[5];
        p.result_6 = lane[6]; p.result_7 = lane[7];
        return p;
    endfunction

    // queue a word and update the shadow state in issue order
    task automatic issue(input t_in_word w);
        case (t_mode'(w.mode))
            MODE_ACT: begin
                act_mem[act_idx(w.row, w.col, w.in_channel)] = w.value;
                act_set[act_idx(w.row, w.col, w.in_channel)] = 1'b1;
            end
            MODE_WGT: if (w.tap < TAPS) begin
                wgt_mem[wgt_idx(w.out_channel, w.in_channel, w.tap)] = w.value;
                wgt_set[wgt_idx(w.out_channel, w.in_channel, w.tap)] = 1'b1;
            end
            MODE_BIAS: begin
                bias_mem[w.out_channel] = w.value;
                bias_set[w.out_channel] = 1'b1;
            end
            default: pixel_q.push_back(predict_pixel(w));
        endcase
        word_q.push_back(w);
    endtask

    function automatic t_in_word mk(input t_mode m, input int r, input int c, input int ic,
                                    input int oc, input int t, input logic signed [7:0] v);
        t_in_word w;
        w.mode = m; w.row = 6'(r); w.col = 6'(c); w.in_channel = 5'(ic);
        w.out_channel = 6'(oc); w.tap = 4'(t); w.value = v;
        return w;
    endfunction

    // load every store entry a query will read that has not been written yet, then issue the query
    task automatic query(input t_in_word w);
        int h, wd, nin, nout, base, r, q;
        h = cap(cfg_h, 64);
        wd = cap(cfg_w, 64);
        nin = cap(cfg_nin, 32);
        nout = cap(cfg_nout, 64);
        base = int'(w.out_channel) / LANES * LANES;
        if (int'(w.row) < h && int'(w.col) < wd) begin
            for (int t = 0; t < TAPS; t++) begin
                r = int'(w.row) + t / 3 - 1;
                q = int'(w.col) + t % 3 - 1;
                if (r >= 0 && q >= 0 && r < h && q < wd)
                    for (int c = 0; c < nin; c++)
                        if (!act_set[act_idx(r, q, c)])
                            issue(mk(MODE_ACT, r, q, c, 0, 0, rand_val()));
            end
            for (int ch = base; ch < base + LANES && ch < nout; ch++) begin
                if (!bias_set[ch]) issue(mk(MODE_BIAS, 0, 0, 0, ch, 0, rand_val()));
                for (int c = 0; c < nin; c++)
                    for (int t = 0; t < TAPS; t++)
                        if (!wgt_set[wgt_idx(ch, c, t)])
                            issue(mk(MODE_WGT, 0, 0, c, ch, t, rand_val()));
            end
        end
        w.mode = MODE_QUERY;
        issue(w);
    endtask

    task automatic wait_idle();
        while (word_q.size() != 0 || start || pixel_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 7'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input int h, input int wd, input int nin, input int nout);
        wait_idle();
        set_reg(CFG_HEIGHT, h);
        set_reg(CFG_WIDTH, wd);
        set_reg(CFG_IN_CH, nin);
        set_reg(CFG_OUT_CH, nout);
        cfg_h = h & 8'h7f;
        cfg_w = wd & 8'h7f;
        cfg_nin = nin & 8'h3f;
        cfg_nout = nout & 8'h7f;
    endtask

    task automatic random_run(input int n, input int query_pct);
        t_in_word w;
        logic [63:0] rnd;
        int h, wd, nin, nout, pick;
        h = cap(cfg_h, 64);
        wd = cap(cfg_w, 64);
        nin = cap(cfg_nin, 32);
        nout = cap(cfg_nout, 64);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            rnd = {$urandom, $urandom};
            w = rnd[$bits(t_in_word)-1:0];
            w.value = rand_val();
            if (pick < query_pct) begin
                if ($urandom_range(0, 4) != 0) begin
                    w.row = 6'($urandom_range(0, (h > 0) ? h - 1 : 63));
                    w.col = 6'($urandom_range(0, (wd > 0) ? wd - 1 : 63));
                end
                query(w);
            end else if (pick < 90) begin
                // valid load, inside the active frame unless the frame is empty
                w.mode = 2'($urandom_range(0, 2));
                w.row = 6'($urandom_range(0, (h > 0) ? h - 1 : 0));
                w.col = 6'($urandom_range(0, (wd > 0) ? wd - 1 : 0));
                w.in_channel = 5'($urandom_range(0, (nin > 0) ? nin - 1 : 0));
                w.out_channel = 6'($urandom_range(0, nout - 1));
                w.tap = 4'($urandom_range(0, 8));
                issue(w);
            end else if (w.mode == MODE_QUERY) begin
                query(w);
            end else begin
                issue(w);
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (gap_cnt > 0) begin
                gap_cnt <= gap_cnt - 1;
                start <= 1'b0;
            end else if (word_q.size() > 0) begin
                i_item <= word_q.pop_front();
                start <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0) gap_cnt <= $urandom_range(1, 11);
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int e, input int a);
        if (e != a) begin
            err_cnt++;
            mism_cnt++;
            if (mism_cnt <= 10) $display("mismatch %s: expected %0d actual %0d", name, e, a);
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid) begin
            if (pixel_q.size() == 0) begin
                err_cnt++;
                $display("unexpected result word at %0t", $time);
            end else begin
                e = pixel_q.pop_front();
                check_field("out_row", e.out_row, o_result.out_row);
                check_field("out_col", e.out_col, o_result.out_col);
                check_field("channel_base", e.channel_base, o_result.channel_base);
                check_field("in_range", e.in_range, o_result.in_range);
                check_field("result_0", e.result_0, o_result.result_0);
                check_field("result_1", e.result_1, o_result.result_1);
                check_field("result_2", e.result_2, o_result.result_2);
                check_field("result_3", e.result_3, o_result.result_3);
                check_field("result_4", e.result_4, o_result.result_4);
                check_field("result_5", e.result_5, o_result.result_5);
                check_field("result_6", e.result_6, o_result.result_6);
                check_field("result_7", e.result_7, o_result.result_7);
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: frame corners, outside, unaligned base, lanes past output_channels
        configure(4, 4, 2, 12);
        issue(mk(MODE_ACT, 0, 0, 0, 0, 0, 8'sd127));
        issue(mk(MODE_ACT, 0, 0, 1, 0, 0, -8'sd128));
        issue(mk(MODE_WGT, 0, 0, 31, 63, 15, -8'sd128));   // tap out of range, ignored
        issue(mk(MODE_WGT, 0, 0, 0, 9, 4, 8'sd127));
        issue(mk(MODE_BIAS, 0, 0, 0, 63, 0, 8'sd127));
        issue(mk(MODE_ACT, 63, 63, 31, 0, 0, -8'sd1));
        query(mk(MODE_QUERY, 0, 0, 0, 0, 0, 0));
        query(mk(MODE_QUERY, 3, 3, 0, 13, 0, 0));
        query(mk(MODE_QUERY, 0, 3, 0, 8, 0, 0));
        query(mk(MODE_QUERY, 63, 63, 31, 63, 15, 0));
        query(mk(MODE_QUERY, 4, 0, 0, 56, 0, 0));
        query(mk(MODE_QUERY, 1, 2, 0, 7, 0, 0));
        issue(mk(MODE_BIAS, 0, 0, 0, 0, 0, -8'sd128));
        query(mk(MODE_QUERY, 1, 1, 0, 0, 0, 0));
        random_run(120, 25);

        configure(2, 1, 0, 127);
        random_run(80, 30);
        configure(0, 5, 3, 16);
        random_run(40, 30);

        // oversized frame and channel counts, one live output channel
        configure(127, 127, 63, 9);
        query(mk(MODE_QUERY, 63, 63, 0, 8, 0, 0));
        query(mk(MODE_QUERY, 63, 63, 0, 20, 0, 0));

        configure(3, 5, 2, 16);
        random_run(120, 25);
        configure(5, 4, 1, 24);
        idle_on = 1'b0;
        random_run(100, 25);

        wait_idle();
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
